FILE: design/rgb_led_fade_command_engine_top_macros.svh
// assertion macros for the rgb led fade command engine
`ifndef RGB_LED_FADE_COMMAND_ENGINE_TOP_MACROS_SVH
`define RGB_LED_FADE_COMMAND_ENGINE_TOP_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define RGBF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rgbf property violated");
// condition must never be seen outside reset
`define RGBF_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rgbf forbidden condition seen");
`else
`define RGBF_ASSERT(label, clk, rst_n, prop)
`define RGBF_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: design/rgbfce_pkg.sv
// shared types, constants and helper functions of the rgb led fade engine
package rgbfce_pkg;

    // default sizes
    localparam int NUM_LEDS_DEF        = 16;
    localparam int SELECTABLE_LEDS_DEF = 16;
    localparam int MAX_REPORT          = 16;

    // field widths
    localparam int LED_INDEX_W = 4;
    localparam int CH_W        = 8;
    localparam int COLOR_W     = 3 * CH_W;
    localparam int CMD_W       = 8;

    // request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    // command letters
    localparam logic [CMD_W-1:0] CMD_SELECT   = 8'h6C; // l
    localparam logic [CMD_W-1:0] CMD_SET_NOW  = 8'h6E; // n
    localparam logic [CMD_W-1:0] CMD_FADE_RGB = 8'h63; // c
    localparam logic [CMD_W-1:0] CMD_FADE_HSV = 8'h68; // h
    localparam logic [CMD_W-1:0] CMD_STEP     = 8'h66; // f

    // hsv and fade constants
    localparam logic [CH_W-1:0] HUE_SPAN   = 8'd43;
    localparam logic [CH_W-1:0] REM_SCALE  = 8'd6;
    localparam logic [CH_W-1:0] CH_MAX     = 8'd255;
    localparam logic [CH_W-1:0] STEP_RESET = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HSV,
        S_WR,
        S_TRD,
        S_TUPD,
        S_TOUT
    } t_state;

    typedef enum logic [2:0] {
        H_REM,
        H_P,
        H_X1,
        H_Q,
        H_X2,
        H_T,
        H_PACK
    } t_hsv_step;

    // move one channel toward its target, landing when close enough
    function automatic logic [CH_W-1:0] slide_channel(input logic [CH_W-1:0] cur,
                                                     input logic [CH_W-1:0] dst,
                                                     input logic [CH_W-1:0] step);
        logic [CH_W-1:0] gap;
        logic [CH_W-1:0] res;
        gap = (cur > dst) ? (cur - dst) : (dst - cur);
        if (gap <= step) begin
            res = dst;
        end else if (cur < dst) begin
            res = cur + step;
        end else begin
            res = cur - step;
        end
        return res;
    endfunction

    // hue sector, hue / 43 by comparing against the sector starts
    function automatic logic [2:0] hsv_region(input logic [CH_W-1:0] h);
        logic [2:0] reg_n;
        if (h >= CH_W'(5 * HUE_SPAN)) begin
            reg_n = 3'd5;
        end else if (h >= CH_W'(4 * HUE_SPAN)) begin
            reg_n = 3'd4;
        end else if (h >= CH_W'(3 * HUE_SPAN)) begin
            reg_n = 3'd3;
        end else if (h >= CH_W'(2 * HUE_SPAN)) begin
            reg_n = 3'd2;
        end else if (h >= HUE_SPAN) begin
            reg_n = 3'd1;
        end else begin
            reg_n = 3'd0;
        end
        return reg_n;
    endfunction

endpackage

FILE: design/rgb_led_fade_command_engine_top.sv
// rgb led fade command engine: command decode, hsv sequencer and fade tick loop
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_req_type i_cmd_code i_arg0 i_arg1 i_arg2
//   color     out        o_valid / i_stall   o_led_index o_red o_green o_blue o_last
//
// select, step and unknown commands complete on acceptance; n and c write every led in turn
// with all leds selected, or only the selected led if it exists; h first runs the hsv steps
// rem, p, x1, q, x2, t and pack on the shared 8x8 multiplier unless the saturation is zero.
// a tick reads the registered color ram, then updates each led and reports the first
// min(NUM_LEDS, 16) of them through the output register, one led per result; output stalls hold the loop.
// reset clears per-led valid bits at once, so no ram clearing pass is needed.
// o_stall is high while any request is in progress.
`include "rgb_led_fade_command_engine_top_macros.svh"
module rgb_led_fade_command_engine_top #(
    parameter int NUM_LEDS        = rgbfce_pkg::NUM_LEDS_DEF,
    parameter int SELECTABLE_LEDS = rgbfce_pkg::SELECTABLE_LEDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [rgbfce_pkg::CMD_W-1:0]        i_cmd_code,
    input  logic [rgbfce_pkg::CH_W-1:0]         i_arg0,
    input  logic [rgbfce_pkg::CH_W-1:0]         i_arg1,
    input  logic [rgbfce_pkg::CH_W-1:0]         i_arg2,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rgbfce_pkg::LED_INDEX_W-1:0]  o_led_index,
    output logic [rgbfce_pkg::CH_W-1:0]         o_red,
    output logic [rgbfce_pkg::CH_W-1:0]         o_green,
    output logic [rgbfce_pkg::CH_W-1:0]         o_blue,
    output logic                                o_last
);

    localparam int CH_W     = rgbfce_pkg::CH_W;
    localparam int COLOR_W  = rgbfce_pkg::COLOR_W;
    localparam int IDX_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int SEL_W    = $clog2(SELECTABLE_LEDS + 1);
    localparam int LAST_RPT = ((NUM_LEDS < rgbfce_pkg::MAX_REPORT) ?
                               NUM_LEDS : rgbfce_pkg::MAX_REPORT) - 1;
    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(NUM_LEDS - 1);

    rgbfce_pkg::t_state    r_state, n_state;
    rgbfce_pkg::t_hsv_step r_hstep, n_hstep;

    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SEL_W-1:0]   r_sel, n_sel;
    logic [CH_W-1:0]    r_step, n_step;
    logic               r_now, n_now;
    logic [COLOR_W-1:0] r_color, n_color;
    logic [CH_W-1:0]    r_h, n_h;
    logic [CH_W-1:0]    r_s, n_s;
    logic [CH_W-1:0]    r_v, n_v;
    logic [2:0]         r_region, n_region;
    logic [CH_W-1:0]    r_rem, n_rem;
    logic [CH_W-1:0]    r_p, n_p;
    logic [CH_W-1:0]    r_x, n_x;
    logic [CH_W-1:0]    r_q, n_q;
    logic [CH_W-1:0]    r_t, n_t;
    logic [NUM_LEDS-1:0] r_cur_vld, n_cur_vld;
    logic [NUM_LEDS-1:0] r_tgt_vld, n_tgt_vld;
    logic               r_cur_vq;
    logic               r_tgt_vq;
    logic               r_out_vld, n_out_vld;
    logic [rgbfce_pkg::LED_INDEX_W-1:0] r_led_index, n_led_index;
    logic [CH_W-1:0]    r_red, n_red;
    logic [CH_W-1:0]    r_green, n_green;
    logic [CH_W-1:0]    r_blue, n_blue;
    logic               r_last, n_last;

    logic               accept;
    logic               sel_hit;
    logic [IDX_W-1:0]   sel_addr;
    logic [IDX_W-1:0]   raddr;
    logic [IDX_W-1:0]   waddr;
    logic               cur_we;
    logic               tgt_we;
    logic [COLOR_W-1:0] cur_wdata;
    logic [COLOR_W-1:0] cur_rdata;
    logic [COLOR_W-1:0] tgt_rdata;
    logic [COLOR_W-1:0] cur_color;
    logic [COLOR_W-1:0] tgt_color;
    logic [COLOR_W-1:0] new_color;
    logic [CH_W-1:0]    mul_a;
    logic [CH_W-1:0]    mul_b;
    logic [2*CH_W-1:0]  prod;
    logic [CH_W-1:0]    prod_hi;
    logic [2:0]         region_c;
    logic [CH_W-1:0]    hue_off;
    logic [CH_W-1:0]    rem_c;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != rgbfce_pkg::S_IDLE);

    // addressing of the selected led
    assign sel_hit  = (r_sel != '0) && (32'(r_sel) <= NUM_LEDS);
    assign sel_addr = IDX_W'(r_sel - SEL_W'(1));

    // read one led ahead during the tick loop, clamped at the last led
    always_comb begin
        case (r_state)
            rgbfce_pkg::S_TUPD, rgbfce_pkg::S_TOUT: begin
                raddr = (r_idx == IDX_END) ? r_idx : IDX_W'(r_idx + 1'b1);
            end
            default: begin
                raddr = r_idx;
            end
        endcase
    end

    // color memories
    rgbfce_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (NUM_LEDS)
    ) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (waddr),
        .i_wdata (cur_wdata),
        .i_raddr (raddr),
        .o_rdata (cur_rdata)
    );

    rgbfce_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (NUM_LEDS)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (waddr),
        .i_wdata (r_color),
        .i_raddr (raddr),
        .o_rdata (tgt_rdata)
    );

    // entries never written read as black
    assign cur_color = r_cur_vq ? cur_rdata : '0;
    assign tgt_color = r_tgt_vq ? tgt_rdata : '0;

    // fade step on all three channels
    assign new_color = {
        rgbfce_pkg::slide_channel(cur_color[2*CH_W +: CH_W], tgt_color[2*CH_W +: CH_W], r_step),
        rgbfce_pkg::slide_channel(cur_color[CH_W +: CH_W], tgt_color[CH_W +: CH_W], r_step),
        rgbfce_pkg::slide_channel(cur_color[0 +: CH_W], tgt_color[0 +: CH_W], r_step)
    };

    // hue sector and scaled remainder
    assign region_c = rgbfce_pkg::hsv_region(r_h);
    assign hue_off  = r_h - CH_W'({5'b0, region_c} * rgbfce_pkg::HUE_SPAN);
    assign rem_c    = CH_W'(hue_off * rgbfce_pkg::REM_SCALE);

    // shared multiplier operand select
    always_comb begin
        case (r_hstep)
            rgbfce_pkg::H_P: begin
                mul_a = r_v;
                mul_b = rgbfce_pkg::CH_MAX - r_s;
            end
            rgbfce_pkg::H_X1: begin
                mul_a = r_s;
                mul_b = r_rem;
            end
            rgbfce_pkg::H_Q, rgbfce_pkg::H_T: begin
                mul_a = r_v;
                mul_b = rgbfce_pkg::CH_MAX - r_x;
            end
            rgbfce_pkg::H_X2: begin
                mul_a = r_s;
                mul_b = rgbfce_pkg::CH_MAX - r_rem;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = (2*CH_W)'(mul_a) * (2*CH_W)'(mul_b);
    assign prod_hi = prod[2*CH_W-1:CH_W];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rgbfce_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req_type == rgbfce_pkg::REQ_TICK) begin
                        n_state = rgbfce_pkg::S_TRD;
                    end else begin
                        case (i_cmd_code)
                            rgbfce_pkg::CMD_SET_NOW, rgbfce_pkg::CMD_FADE_RGB: begin
                                n_state = rgbfce_pkg::S_WR;
                            end
                            rgbfce_pkg::CMD_FADE_HSV: begin
                                n_state = (i_arg1 == '0) ? rgbfce_pkg::S_WR
                                                         : rgbfce_pkg::S_HSV;
                            end
                            default: begin
                                n_state = rgbfce_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end
            rgbfce_pkg::S_HSV: begin
                if (r_hstep == rgbfce_pkg::H_PACK) begin
                    n_state = rgbfce_pkg::S_WR;
                end
            end
            rgbfce_pkg::S_WR: begin
                if (!((r_sel == '0) && (r_idx != IDX_END))) begin
                    n_state = rgbfce_pkg::S_IDLE;
                end
            end
            rgbfce_pkg::S_TRD: begin
                n_state = rgbfce_pkg::S_TUPD;
            end
            rgbfce_pkg::S_TUPD: begin
                if (32'(r_idx) < rgbfce_pkg::MAX_REPORT) begin
                    n_state = rgbfce_pkg::S_TOUT;
                end else if (r_idx == IDX_END) begin
                    n_state = rgbfce_pkg::S_IDLE;
                end
            end
            rgbfce_pkg::S_TOUT: begin
                if (!i_stall) begin
                    n_state = (r_idx == IDX_END) ? rgbfce_pkg::S_IDLE : rgbfce_pkg::S_TUPD;
                end
            end
            default: begin
                n_state = rgbfce_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory writes and output register loads
    always_comb begin
        n_hstep     = r_hstep;
        n_idx       = r_idx;
        n_sel       = r_sel;
        n_step      = r_step;
        n_now       = r_now;
        n_color     = r_color;
        n_h         = r_h;
        n_s         = r_s;
        n_v         = r_v;
        n_region    = r_region;
        n_rem       = r_rem;
        n_p         = r_p;
        n_x         = r_x;
        n_q         = r_q;
        n_t         = r_t;
        n_cur_vld   = r_cur_vld;
        n_tgt_vld   = r_tgt_vld;
        n_out_vld   = r_out_vld;
        n_led_index = r_led_index;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_last      = r_last;
        waddr       = r_idx;
        cur_we      = 1'b0;
        tgt_we      = 1'b0;
        cur_wdata   = r_color;
        case (r_state)
            rgbfce_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_h   = i_arg0;
                    n_s   = i_arg1;
                    n_v   = i_arg2;
                    if (i_req_type == rgbfce_pkg::REQ_CMD) begin
                        case (i_cmd_code)
                            rgbfce_pkg::CMD_SELECT: begin
                                n_sel = (32'(i_arg0) > SELECTABLE_LEDS) ? '0
                                                                        : SEL_W'(i_arg0);
                            end
                            rgbfce_pkg::CMD_STEP: begin
                                n_step = i_arg0;
                            end
                            rgbfce_pkg::CMD_SET_NOW: begin
                                n_color = {i_arg0, i_arg1, i_arg2};
                                n_now   = 1'b1;
                            end
                            rgbfce_pkg::CMD_FADE_RGB: begin
                                n_color = {i_arg0, i_arg1, i_arg2};
                                n_now   = 1'b0;
                            end
                            rgbfce_pkg::CMD_FADE_HSV: begin
                                // grey at the value level unless the sequencer overrides
                                n_color = {i_arg2, i_arg2, i_arg2};
                                n_now   = 1'b0;
                                n_hstep = rgbfce_pkg::H_REM;
                            end
                            default: begin
                                n_now = r_now;
                            end
                        endcase
                    end
                end
            end
            rgbfce_pkg::S_HSV: begin
                case (r_hstep)
                    rgbfce_pkg::H_REM: begin
                        n_region = region_c;
                        n_rem    = rem_c;
                        n_hstep  = rgbfce_pkg::H_P;
                    end
                    rgbfce_pkg::H_P: begin
                        n_p     = prod_hi;
                        n_hstep = rgbfce_pkg::H_X1;
                    end
                    rgbfce_pkg::H_X1: begin
                        n_x     = prod_hi;
                        n_hstep = rgbfce_pkg::H_Q;
                    end
                    rgbfce_pkg::H_Q: begin
                        n_q     = prod_hi;
                        n_hstep = rgbfce_pkg::H_X2;
                    end
                    rgbfce_pkg::H_X2: begin
                        n_x     = prod_hi;
                        n_hstep = rgbfce_pkg::H_T;
                    end
                    rgbfce_pkg::H_T: begin
                        n_t     = prod_hi;
                        n_hstep = rgbfce_pkg::H_PACK;
                    end
                    default: begin
                        // channel order by hue sector
                        case (r_region)
                            3'd0:    n_color = {r_v, r_t, r_p};
                            3'd1:    n_color = {r_q, r_v, r_p};
                            3'd2:    n_color = {r_p, r_v, r_t};
                            3'd3:    n_color = {r_p, r_q, r_v};
                            3'd4:    n_color = {r_t, r_p, r_v};
                            default: n_color = {r_v, r_p, r_q};
                        endcase
                        n_hstep = rgbfce_pkg::H_REM;
                    end
                endcase
            end
            rgbfce_pkg::S_WR: begin
                // sweep all leds, or write the selected one if it exists
                waddr     = (r_sel == '0) ? r_idx : sel_addr;
                tgt_we    = (r_sel == '0) || sel_hit;
                cur_we    = tgt_we && r_now;
                cur_wdata = r_color;
                if ((r_sel == '0) && (r_idx != IDX_END)) begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            rgbfce_pkg::S_TUPD: begin
                waddr     = r_idx;
                cur_we    = 1'b1;
                cur_wdata = new_color;
                if (32'(r_idx) < rgbfce_pkg::MAX_REPORT) begin
                    n_out_vld   = 1'b1;
                    n_led_index = rgbfce_pkg::LED_INDEX_W'(r_idx);
                    n_red       = new_color[2*CH_W +: CH_W];
                    n_green     = new_color[CH_W +: CH_W];
                    n_blue      = new_color[0 +: CH_W];
                    n_last      = (32'(r_idx) == LAST_RPT);
                end else if (r_idx != IDX_END) begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            rgbfce_pkg::S_TOUT: begin
                if (!i_stall) begin
                    n_out_vld = 1'b0;
                    if (r_idx != IDX_END) begin
                        n_idx = IDX_W'(r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_out_vld = 1'b0;
            end
        endcase
        // mark written entries
        if (cur_we) begin
            n_cur_vld[waddr] = 1'b1;
        end
        if (tgt_we) begin
            n_tgt_vld[waddr] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rgbfce_pkg::S_IDLE;
            r_hstep   <= rgbfce_pkg::H_REM;
            r_idx     <= '0;
            r_sel     <= '0;
            r_step    <= rgbfce_pkg::STEP_RESET;
            r_cur_vld <= '0;
            r_tgt_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hstep   <= n_hstep;
            r_idx     <= n_idx;
            r_sel     <= n_sel;
            r_step    <= n_step;
            r_cur_vld <= n_cur_vld;
            r_tgt_vld <= n_tgt_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_color     <= n_color;
        r_h         <= n_h;
        r_s         <= n_s;
        r_v         <= n_v;
        r_region    <= n_region;
        r_rem       <= n_rem;
        r_p         <= n_p;
        r_x         <= n_x;
        r_q         <= n_q;
        r_t         <= n_t;
        r_cur_vq    <= r_cur_vld[raddr];
        r_tgt_vq    <= r_tgt_vld[raddr];
        r_led_index <= n_led_index;
        r_red       <= n_red;
        r_green     <= n_green;
        r_blue      <= n_blue;
        r_last      <= n_last;
    end

    assign o_valid     = r_out_vld;
    assign o_led_index = r_led_index;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_last      = r_last;

    // checks
    `RGBF_NEVER(a_result_while_idle, i_clk, i_rst_n, r_out_vld && !o_stall)
    `RGBF_NEVER(a_no_write_idle, i_clk, i_rst_n, (r_state == rgbfce_pkg::S_IDLE) && (cur_we || tgt_we))
    `RGBF_NEVER(a_sel_in_range, i_clk, i_rst_n, 32'(r_sel) > SELECTABLE_LEDS)
    `RGBF_ASSERT(a_tick_starts_read, i_clk, i_rst_n, (accept && (i_req_type == rgbfce_pkg::REQ_TICK)) |=> (r_state == rgbfce_pkg::S_TRD))
    `RGBF_ASSERT(a_final_led_ends, i_clk, i_rst_n, (r_out_vld && !i_stall && (r_idx == IDX_END)) |=> (r_state == rgbfce_pkg::S_IDLE))

endmodule

FILE: design/rgbfce_ram.sv
// generic single write port ram with registered read
module rgbfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
